/* src/psc_pkg.sv */
// Shared types and constants of the postfix stack calculator.
`timescale 1ns / 1ps
package psc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 3;

  localparam logic [KindW-1:0] KIND_NUMBER = 3'd0;
  localparam logic [KindW-1:0] KIND_ADD    = 3'd1;
  localparam logic [KindW-1:0] KIND_SUB    = 3'd2;
  localparam logic [KindW-1:0] KIND_MUL    = 3'd3;
  localparam logic [KindW-1:0] KIND_DIV    = 3'd4;
  localparam logic [KindW-1:0] KIND_NEG    = 3'd5;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic             valid;
    alu_op_e          op;
    logic [DataW-1:0] lhs;
    logic [DataW-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

/* src/psc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module psc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/psc_alu.sv */
// Iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
`timescale 1ns / 1ps
module psc_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psc_pkg::alu_req_t   req_i,
  output psc_pkg::alu_rsp_t   rsp_o
);
  import psc_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_RUN  = 3'b010,
    P_FIX  = 3'b100
  } phase_e;

  phase_e           phase_q, phase_d;
  alu_op_e          op_q, op_d;
  logic [4:0]       step_q, step_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] x_q, x_d;
  logic [DataW-1:0] y_q, y_d;
  logic             neg_q, neg_d;
  logic             zero_q, zero_d;
  logic [DataW-1:0] res_q, res_d;
  logic             done_q, done_d;

  logic [DataW:0]   opl;
  logic [DataW:0]   opr;
  logic             sub;
  logic [DataW+1:0] sum;
  logic             ge;
  logic [DataW-1:0] lhs_mag;
  logic [DataW-1:0] rhs_mag;
  logic [DataW-1:0] q_next;

  assign lhs_mag = req_i.lhs[DataW-1] ? (DataW'(0) - req_i.lhs) : req_i.lhs;
  assign rhs_mag = req_i.rhs[DataW-1] ? (DataW'(0) - req_i.rhs) : req_i.rhs;

  always_comb begin
    opl = '0;
    opr = '0;
    sub = 1'b0;
    if (phase_q == P_FIX) begin
      opr = {1'b0, x_q};
      sub = 1'b1;
    end else begin
      case (op_q)
        ALU_ADD: begin
          opl = {1'b0, x_q};
          opr = {1'b0, y_q};
        end
        ALU_SUB: begin
          opl = {1'b0, x_q};
          opr = {1'b0, y_q};
          sub = 1'b1;
        end
        ALU_MUL: begin
          opl = {1'b0, acc_q};
          opr = x_q[0] ? {1'b0, y_q} : '0;
        end
        default: begin
          opl = {acc_q, x_q[DataW-1]};
          opr = {1'b0, y_q};
          sub = 1'b1;
        end
      endcase
    end
    sum = sub ? ({1'b0, opl} - {1'b0, opr}) : ({1'b0, opl} + {1'b0, opr});
  end

  assign ge     = ~sum[DataW+1];
  assign q_next = {x_q[DataW-2:0], ge};

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    step_d  = step_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (phase_q)
      P_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.op;
          step_d  = '0;
          acc_d   = '0;
          neg_d   = req_i.lhs[DataW-1] ^ req_i.rhs[DataW-1];
          zero_d  = (req_i.rhs == '0);
          phase_d = P_RUN;
          case (req_i.op)
            ALU_MUL: begin
              x_d = req_i.rhs;
              y_d = req_i.lhs;
            end
            ALU_DIV: begin
              x_d = lhs_mag;
              y_d = rhs_mag;
            end
            default: begin
              x_d = req_i.lhs;
              y_d = req_i.rhs;
            end
          endcase
        end
      end
      P_RUN: begin
        step_d = step_q + 5'd1;
        case (op_q)
          ALU_MUL: begin
            acc_d = sum[DataW-1:0];
            x_d   = {1'b0, x_q[DataW-1:1]};
            y_d   = {y_q[DataW-2:0], 1'b0};
            if (&step_q) begin
              res_d   = sum[DataW-1:0];
              done_d  = 1'b1;
              phase_d = P_IDLE;
            end
          end
          ALU_DIV: begin
            acc_d = ge ? sum[DataW-1:0] : opl[DataW-1:0];
            x_d   = q_next;
            if (&step_q) begin
              if (zero_q) begin
                res_d   = '0;
                done_d  = 1'b1;
                phase_d = P_IDLE;
              end else if (neg_q) begin
                phase_d = P_FIX;
              end else begin
                res_d   = q_next;
                done_d  = 1'b1;
                phase_d = P_IDLE;
              end
            end
          end
          default: begin
            res_d   = sum[DataW-1:0];
            done_d  = 1'b1;
            phase_d = P_IDLE;
          end
        endcase
      end
      P_FIX: begin
        res_d   = sum[DataW-1:0];
        done_d  = 1'b1;
        phase_d = P_IDLE;
      end
      default: begin
        phase_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

/* src/postfix_stack_calculator_core.sv */
// Postfix stack calculator: token sequencer, value stack RAM and shared ALU.
// Divide runs 32 steps of the shared ALU; a negative quotient adds one more step.
// A token with the end mark also pops the result off the stack and may wait on the output side.
// One token at a time: a new token is taken only when the sequencer is idle.
// Reset (asynchronous, active low) empties the stack and drops any pending result.
`timescale 1ns / 1ps
module postfix_stack_calculator_core #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [psc_pkg::KindW-1:0]      kind_i,
  input  logic signed [psc_pkg::DataW-1:0] number_value_i,
  input  logic                           end_of_expr_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [psc_pkg::DataW-1:0] result_value_o
);
  import psc_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POP  = 7'b0000010,
    S_CAP  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_WAIT = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic             eoe_q, eoe_d;
  logic             two_q, two_d;
  logic             second_q, second_d;
  logic             empty_q, empty_d;
  alu_op_e          op_q, op_d;
  logic [DataW-1:0] a_q, a_d;
  logic [DataW-1:0] b_q, b_d;
  logic [DataW-1:0] result_q, result_d;

  logic             mem_we;
  logic [CntW-1:0]  mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [CntW-1:0]  mem_raddr;
  logic [DataW-1:0] mem_rdata;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  logic             in_xfer;
  logic             not_full;
  logic [DataW-1:0] pop_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign not_full   = (cnt_q < CntW'(DEPTH - 1));
  assign pop_val    = empty_q ? '0 : mem_rdata;

  assign alu_req.valid = (state_q == S_EXEC);
  assign alu_req.op    = op_q;
  assign alu_req.lhs   = b_q;
  assign alu_req.rhs   = a_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    eoe_d       = eoe_q;
    two_d       = two_q;
    second_d    = second_q;
    empty_d     = empty_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    result_d    = result_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q;
    mem_wdata   = alu_rsp.result;
    mem_re      = 1'b0;
    mem_raddr   = cnt_q - CntW'(1);
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          eoe_d    = end_of_expr_i;
          second_d = 1'b0;
          two_d    = 1'b1;
          case (kind_i)
            KIND_NUMBER: begin
              mem_wdata = number_value_i;
              if (not_full) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
              end
              state_d = S_FIN;
            end
            KIND_ADD: begin
              op_d    = ALU_ADD;
              state_d = S_POP;
            end
            KIND_SUB: begin
              op_d    = ALU_SUB;
              state_d = S_POP;
            end
            KIND_MUL: begin
              op_d    = ALU_MUL;
              state_d = S_POP;
            end
            KIND_DIV: begin
              op_d    = ALU_DIV;
              state_d = S_POP;
            end
            KIND_NEG: begin
              op_d    = ALU_SUB;
              two_d   = 1'b0;
              b_d     = '0;
              state_d = S_POP;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_POP: begin
        empty_d = (cnt_q == '0);
        if (cnt_q != '0) begin
          mem_re = 1'b1;
          cnt_d  = cnt_q - CntW'(1);
        end
        state_d = S_CAP;
      end
      S_CAP: begin
        if (fin_q) begin
          result_d = pop_val;
          state_d  = S_EMIT;
        end else if (!second_q) begin
          a_d = pop_val;
          if (two_q) begin
            second_d = 1'b1;
            state_d  = S_POP;
          end else begin
            state_d = S_EXEC;
          end
        end else begin
          b_d     = pop_val;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          if (not_full) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (eoe_q) begin
          fin_d   = 1'b1;
          state_d = S_POP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = result_q;
          cnt_d       = '0;
          fin_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    eoe_q      <= eoe_d;
    two_q      <= two_d;
    second_q   <= second_d;
    empty_q    <= empty_d;
    op_q       <= op_d;
    a_q        <= a_d;
    b_q        <= b_d;
    result_q   <= result_d;
  end

  psc_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  psc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_data_q;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the postfix stack calculator core.
`timescale 1ns / 1ps
module tb_top;
  import psc_pkg::*;

  localparam int unsigned Depth = 128;
  localparam logic [KindW-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KindW-1:0] KIND_RSVD7 = 3'd7;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] num;
    logic             last;
  } token_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [KindW-1:0]         kind_i = KIND_NUMBER;
  logic signed [DataW-1:0]  number_value_i = '0;
  logic                     end_of_expr_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DataW-1:0]  result_value_o;

  postfix_stack_calculator_core #(.DEPTH(Depth)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .number_value_i (number_value_i),
    .end_of_expr_i  (end_of_expr_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o)
  );

  token_t           token_q[$];
  logic [DataW-1:0] result_q[$];
  token_t           cur_tok;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;
  logic             hold_req = 1'b0;
  logic             rx_hold = 1'b0;
  int unsigned      n_fail = 0;

  logic [KindW-1:0] bin_ops [4] = '{KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV};
  logic [DataW-1:0] corner_vals [5] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000};

  logic [DataW-1:0] calc_stack [Depth-1];
  int unsigned      calc_depth = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] stack_pop();
    if (calc_depth == 0) return '0;
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  function automatic void stack_push(input logic [DataW-1:0] v);
    if (calc_depth < Depth - 1) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endfunction

  function automatic logic [DataW-1:0] div_toward_zero(input logic [DataW-1:0] b,
                                                       input logic [DataW-1:0] a);
    logic [DataW-1:0] mb, ma, q;
    if (a == '0) return '0;
    mb = b[DataW-1] ? 32'd0 - b : b;
    ma = a[DataW-1] ? 32'd0 - a : a;
    q  = mb / ma;
    return (b[DataW-1] ^ a[DataW-1]) ? 32'd0 - q : q;
  endfunction

  function automatic bit apply_token(input token_t t, output logic [DataW-1:0] res);
    logic [DataW-1:0] a, b;
    res = '0;
    case (t.kind)
      KIND_NUMBER: stack_push(t.num);
      KIND_ADD: begin
        a = stack_pop();
        b = stack_pop();
        stack_push(b + a);
      end
      KIND_SUB: begin
        a = stack_pop();
        b = stack_pop();
        stack_push(b - a);
      end
      KIND_MUL: begin
        a = stack_pop();
        b = stack_pop();
        stack_push(b * a);
      end
      KIND_DIV: begin
        a = stack_pop();
        b = stack_pop();
        stack_push(div_toward_zero(b, a));
      end
      KIND_NEG: begin
        a = stack_pop();
        stack_push(32'd0 - a);
      end
      default: ;
    endcase
    if (!t.last) return 1'b0;
    res = stack_pop();
    calc_depth = 0;
    return 1'b1;
  endfunction

  function automatic logic [DataW-1:0] rand_operand();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(20) - 10;
      2: return corner_vals[$urandom_range(4)];
      default: return $urandom_range(1000) - 500;
    endcase
  endfunction

  task automatic put_token(input logic [KindW-1:0] kind, input logic [DataW-1:0] num,
                           input logic last);
    token_t t;
    t.kind = kind;
    t.num  = num;
    t.last = last;
    token_q.push_back(t);
  endtask

  task automatic gen_expr(input int unsigned max_nums, inout int unsigned n_items);
    token_t      seq[$];
    token_t      t;
    int unsigned left, d;
    left = $urandom_range(1, max_nums);
    d = 0;
    while (left != 0 || d > 1) begin
      t.num  = $urandom;
      t.last = 1'b0;
      if (left != 0 && (d < 2 || $urandom_range(2) == 0)) begin
        t.kind = KIND_NUMBER;
        t.num  = rand_operand();
        left--;
        d++;
      end else begin
        t.kind = bin_ops[$urandom_range(3)];
        d--;
      end
      seq.push_back(t);
      if ($urandom_range(7) == 0) begin
        t.kind = KIND_NEG;
        t.num  = $urandom;
        seq.push_back(t);
      end
    end
    seq[seq.size()-1].last = 1'b1;
    foreach (seq[i]) token_q.push_back(seq[i]);
    n_items += seq.size();
  endtask

  task automatic gen_noise(inout int unsigned n_items);
    logic [KindW-1:0] k;
    int unsigned      n;
    n = $urandom_range(1, 6);
    for (int unsigned i = 0; i < n; i++) begin
      k = KindW'($urandom_range(7));
      put_token(k, rand_operand(), (i == n - 1) || ($urandom_range(3) == 0));
      if (k != KIND_RSVD6 && k != KIND_RSVD7) n_items++;
    end
  endtask

  task automatic gen_overflow(inout int unsigned n_items);
    for (int unsigned i = 0; i < Depth + 2; i++) put_token(KIND_NUMBER, $urandom, 1'b0);
    put_token(KIND_ADD, $urandom, 1'b0);
    put_token(KIND_NEG, $urandom, 1'b0);
    put_token(KIND_SUB, $urandom, 1'b1);
    n_items += Depth + 5;
  endtask

  task automatic wait_sent();
    while (token_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  // Hold the output side for a long stretch so the core backs up.
  initial begin : holdoff
    wait (hold_req);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin : driver
    logic [DataW-1:0] r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (apply_token(cur_tok, r)) result_q.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (token_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_tok = token_q.pop_front();
          in_valid_i     <= 1'b1;
          kind_i         <= cur_tok.kind;
          number_value_i <= cur_tok.num;
          end_of_expr_i  <= cur_tok.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    logic [DataW-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result_value: expected none, actual %0d", result_value_o);
          n_fail++;
        end else begin
          want = result_q.pop_front();
          if (result_value_o !== want) begin
            $error("result_value: expected %0d, actual %0d", $signed(want), result_value_o);
            n_fail++;
          end
        end
      end
      out_stall_i <= rx_hold || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : stimulus
    int unsigned n_items;
    int unsigned idle_set [4];
    int unsigned stall_set [4];
    idle_set = '{0, 75, 0, 18};
    stall_set = '{0, 0, 75, 18};
    n_items = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // wraparound, division corners, negate, clear on end, empty pops, reserved kinds
    put_token(KIND_NUMBER, 32'h7FFF_FFFF, 1'b0);
    put_token(KIND_NUMBER, 32'h0000_0001, 1'b0);
    put_token(KIND_ADD, $urandom, 1'b1);
    put_token(KIND_NUMBER, 32'h8000_0000, 1'b0);
    put_token(KIND_NUMBER, 32'hFFFF_FFFF, 1'b0);
    put_token(KIND_DIV, $urandom, 1'b1);
    put_token(KIND_NUMBER, 32'd7, 1'b0);
    put_token(KIND_NUMBER, 32'd0, 1'b0);
    put_token(KIND_DIV, $urandom, 1'b1);
    put_token(KIND_NUMBER, -32'sd7, 1'b0);
    put_token(KIND_NUMBER, 32'd2, 1'b0);
    put_token(KIND_DIV, $urandom, 1'b1);
    put_token(KIND_NUMBER, 32'h8000_0000, 1'b0);
    put_token(KIND_NEG, $urandom, 1'b1);
    put_token(KIND_NUMBER, 32'd3, 1'b0);
    put_token(KIND_NUMBER, 32'd5, 1'b0);
    put_token(KIND_SUB, $urandom, 1'b0);
    put_token(KIND_NUMBER, 32'hFFFF_FFFF, 1'b0);
    put_token(KIND_MUL, $urandom, 1'b1);
    put_token(KIND_NUMBER, 32'd1, 1'b0);
    put_token(KIND_NUMBER, 32'd2, 1'b1);
    put_token(KIND_ADD, $urandom, 1'b1);
    put_token(KIND_NUMBER, 32'd9, 1'b0);
    put_token(KIND_RSVD6, $urandom, 1'b0);
    put_token(KIND_RSVD7, $urandom, 1'b1);
    put_token(KIND_NEG, $urandom, 1'b1);
    wait_sent();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      n_items = 0;
      if (p == 0 || p == 3) gen_overflow(n_items);
      while (n_items < 200) begin
        if ($urandom_range(99) < 85) gen_expr(($urandom_range(9) == 0) ? 20 : 6, n_items);
        else gen_noise(n_items);
      end
      wait_sent();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    n_items = 0;
    while (n_items < 40) gen_expr(4, n_items);
    wait_sent();

    while (result_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* postfix_stack_calculator_core.f */
src/psc_pkg.sv
src/psc_ram.sv
src/psc_alu.sv
src/postfix_stack_calculator_core.sv
tb/sv/tb_top.sv
